// ===== rtl/sca_pkg.sv =====
// package for the sound channel allocator: request/result item types,
// opcodes, status codes and the find-first helper. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sca_pkg;

  // widest supported channel count and the fixed channel field width
  localparam int unsigned MAX_CHANNELS     = 64;
  localparam int unsigned NUM_CHANNELS_DEF = 64;
  localparam int unsigned CH_W             = 6;

  typedef enum logic [1:0] {
    OP_FIND    = 2'd0,
    OP_RESERVE = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FAIL = 1'b1
  } status_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic            stereo;
    logic [CH_W-1:0] channel;
  } req_t;

  typedef struct packed {
    logic [CH_W-1:0] channel_res;
    logic            status;
  } res_t;

  // index of the lowest set bit, zero when nothing is set
  function automatic logic [CH_W-1:0] lowest_set(input logic [MAX_CHANNELS-1:0] vec);
    logic [CH_W-1:0] idx;
    idx = '0;
    for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = CH_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sound_channel_allocator.sv =====
// sound channel allocator: reserved-channel mask with rotating find pointer.
// an accepted item goes through the input register, then the result register.
// throughput: one item per cycle while out_stall_i is low; a find is a rotated
// find-first over the mask; a reserve picks the lowest free, a release frees one.
// reset: mask and search pointer cleared, both pipeline registers empty.
// depends on sca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sound_channel_allocator
  import sca_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      out_data_o
);

  localparam int unsigned SUM_W = CH_W + 1;

  // pipeline registers
  logic                    req_valid_q, res_valid_q;
  req_t                    req_q;
  res_t                    res_q, res_d;
  logic [NUM_CHANNELS-1:0] mask_q, mask_d;
  logic [CH_W-1:0]         ptr_q, ptr_d;

  // handshake: request stage moves on when result register is free or drained
  logic res_free, req_adv, req_load;
  assign res_free   = !res_valid_q || !out_stall_i;
  assign req_adv    = req_valid_q && res_free;
  assign in_stall_o = req_valid_q && !res_free;
  assign req_load   = in_valid_i && !in_stall_o;

  // qualify channels for the find, stereo needs the channel above free too
  logic [NUM_CHANNELS-1:0] free_vec, qual_vec, ge_vec;
  assign free_vec = ~mask_q;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_qual
    if (i < NUM_CHANNELS - 1) begin : g_pair
      assign qual_vec[i] = free_vec[i] && (!req_q.stereo || free_vec[i+1]);
    end else begin : g_last
      assign qual_vec[i] = free_vec[i] && !req_q.stereo;
    end
    assign ge_vec[i] = (CH_W'(i) >= ptr_q);
  end

  // rotated search: first qualified at or above pointer, else wrap to lowest
  logic [MAX_CHANNELS-1:0] qual_ext, hi_ext, free_ext;
  logic [CH_W-1:0]         find_idx, rsv_idx;
  logic                    find_any, rsv_any;
  logic [SUM_W-1:0]        ptr_sum;

  assign qual_ext = MAX_CHANNELS'(qual_vec);
  assign hi_ext   = MAX_CHANNELS'(qual_vec & ge_vec);
  assign free_ext = MAX_CHANNELS'(free_vec);
  assign find_any = |qual_ext;
  assign find_idx = (|hi_ext) ? lowest_set(hi_ext) : lowest_set(qual_ext);
  assign rsv_any  = |free_ext;
  assign rsv_idx  = lowest_set(free_ext);
  assign ptr_sum  = {1'b0, find_idx} + (req_q.stereo ? SUM_W'(2) : SUM_W'(1));

  // request decode and state update
  always_comb begin
    mask_d            = mask_q;
    ptr_d             = ptr_q;
    res_d.channel_res = '0;
    res_d.status      = STATUS_FAIL;
    unique case (opcode_e'(req_q.opcode))
      OP_FIND: begin
        if (find_any) begin
          res_d.channel_res = find_idx;
          res_d.status      = STATUS_OK;
          if (ptr_sum >= SUM_W'(NUM_CHANNELS)) begin
            ptr_d = CH_W'(ptr_sum - SUM_W'(NUM_CHANNELS));
          end else begin
            ptr_d = CH_W'(ptr_sum);
          end
        end
      end
      OP_RESERVE: begin
        if (rsv_any) begin
          res_d.channel_res = rsv_idx;
          res_d.status      = STATUS_OK;
          mask_d            = mask_q | (NUM_CHANNELS'(1) << rsv_idx);
        end
      end
      OP_RELEASE: begin
        res_d.channel_res = req_q.channel;
        if ({1'b0, req_q.channel} < SUM_W'(NUM_CHANNELS)) begin
          res_d.status = STATUS_OK;
          mask_d       = mask_q & ~(NUM_CHANNELS'(1) << req_q.channel);
        end
      end
      default: begin
        res_d.channel_res = '0;
        res_d.status      = STATUS_FAIL;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      mask_q      <= '0;
      ptr_q       <= '0;
    end else begin
      if (req_load) begin
        req_valid_q <= 1'b1;
      end else if (req_adv) begin
        req_valid_q <= 1'b0;
      end
      if (req_adv) begin
        res_valid_q <= 1'b1;
        mask_q      <= mask_d;
        ptr_q       <= ptr_d;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_q <= in_data_i;
    end
    if (req_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire
